>>> sv/p2lh_pkg.sv
// Shared types and constants for the power-of-two latency histogram.
package p2lh_pkg;

  // Default number of bins.
  localparam int unsigned BIN_COUNT_DEF = 32;

  // Command carried on the input side-band.
  typedef enum logic [1:0] {
    CMD_LATENCY = 2'd0,
    CMD_VALUE   = 2'd1,
    CMD_READ    = 2'd2
  } cmd_e;

  // Result status carried on the output side-band.
  typedef enum logic [1:0] {
    ST_RECORDED = 2'd0,
    ST_DROPPED  = 2'd1,
    ST_READ     = 2'd2
  } status_e;

  localparam logic signed [31:0] NS_PER_S  = 32'sd1000000000;
  localparam logic signed [20:0] US_PER_S  = 21'sd1000000;
  localparam logic [30:0]        ROUND_UP  = 31'd999;
  // Second differences beyond this always land past the last bin.
  localparam logic signed [63:0] SEC_LIMIT = 64'sh0000_1000_0000_0000;
  // floor(x / 1000) = (x * DIV_RECIP) >> DIV_SHIFT, exact for x below 2^31.
  localparam logic [31:0]        DIV_RECIP = 32'd2199023256;
  localparam int unsigned        DIV_SHIFT = 41;

  // Item leaving the duration pipeline.
  typedef struct packed {
    cmd_e        cmd;
    logic        drop;
    logic [63:0] us;
    logic [4:0]  read_index;
  } us_item_t;

  // Item leaving the bin-index pipeline.
  typedef struct packed {
    cmd_e        cmd;
    logic        drop;
    logic [6:0]  k;
    logic [4:0]  read_index;
  } bin_item_t;

endpackage

>>> sv/p2lh_dur.sv
// Duration pipeline: timestamp difference, range checks, rounding to microseconds.
module p2lh_dur (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                en_i,
  input  logic                vld_i,
  input  p2lh_pkg::cmd_e      cmd_i,
  input  logic [62:0]         start_sec_i,
  input  logic [29:0]         start_nsec_i,
  input  logic [62:0]         end_sec_i,
  input  logic [29:0]         end_nsec_i,
  input  logic [30:0]         plain_value_i,
  input  logic [4:0]          read_index_i,
  output logic                vld_o,
  output p2lh_pkg::us_item_t  item_o
);

  // stage 1: raw differences
  logic               s1_vld_q;
  p2lh_pkg::cmd_e     s1_cmd_q;
  logic signed [63:0] s1_dsec_q;
  logic signed [30:0] s1_dns_q;
  logic [30:0]        s1_plain_q;
  logic [4:0]         s1_ridx_q;

  // stage 2: range checks and divide operand
  logic               s2_vld_q;
  p2lh_pkg::cmd_e     s2_cmd_q;
  logic               s2_drop_q;
  logic signed [45:0] s2_dsec_q;
  logic [30:0]        s2_mag_q;
  logic               s2_neg_q;
  logic [30:0]        s2_plain_q;
  logic [4:0]         s2_ridx_q;

  // stage 3: products
  logic               s3_vld_q;
  p2lh_pkg::cmd_e     s3_cmd_q;
  logic               s3_drop_q;
  logic signed [63:0] s3_base_q;
  logic [62:0]        s3_prod_q;
  logic               s3_neg_q;
  logic [30:0]        s3_plain_q;
  logic [4:0]         s3_ridx_q;

  // stage 4: microseconds
  logic               s4_vld_q;
  p2lh_pkg::us_item_t s4_item_q, s4_item_d;

  logic               drop_c;
  logic [30:0]        mag_c;
  logic signed [66:0] base_full_c;
  logic [62:0]        quo_full_c;
  logic [21:0]        quo_c;
  logic signed [63:0] quo_s_c;

  always_comb begin
    // end before start, or far enough out that no bin can hold it
    drop_c = (s1_dsec_q < -64'sd1) || (s1_dsec_q > p2lh_pkg::SEC_LIMIT)
          || (s1_dsec_q == 64'sd0 && s1_dns_q < 31'sd0)
          || (s1_dsec_q == 64'sd1 && 32'(s1_dns_q) < -p2lh_pkg::NS_PER_S)
          || (s1_dsec_q == -64'sd1 && 32'(s1_dns_q) < p2lh_pkg::NS_PER_S);
    // ceil for non-negative, floor of magnitude for negative
    if (s1_dns_q[30]) begin
      mag_c = ~$unsigned(s1_dns_q) + 31'd1;
    end else begin
      mag_c = $unsigned(s1_dns_q) + p2lh_pkg::ROUND_UP;
    end
  end

  assign base_full_c = s2_dsec_q * p2lh_pkg::US_PER_S;

  always_comb begin
    quo_full_c = s3_prod_q >> p2lh_pkg::DIV_SHIFT;
    quo_c      = quo_full_c[21:0];
    quo_s_c    = s3_neg_q ? -$signed(64'(quo_c)) : $signed(64'(quo_c));
    s4_item_d.cmd        = s3_cmd_q;
    s4_item_d.drop       = s3_drop_q;
    s4_item_d.read_index = s3_ridx_q;
    if (s3_cmd_q == p2lh_pkg::CMD_VALUE) begin
      s4_item_d.us = 64'(s3_plain_q);
    end else begin
      s4_item_d.us = $unsigned(s3_base_q + quo_s_c);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_vld_q <= 1'b0;
      s2_vld_q <= 1'b0;
      s3_vld_q <= 1'b0;
      s4_vld_q <= 1'b0;
    end else if (en_i) begin
      s1_vld_q <= vld_i;
      s2_vld_q <= s1_vld_q;
      s3_vld_q <= s2_vld_q;
      s4_vld_q <= s3_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      s1_cmd_q   <= cmd_i;
      s1_dsec_q  <= $signed({1'b0, end_sec_i}) - $signed({1'b0, start_sec_i});
      s1_dns_q   <= $signed({1'b0, end_nsec_i}) - $signed({1'b0, start_nsec_i});
      s1_plain_q <= plain_value_i;
      s1_ridx_q  <= read_index_i;

      s2_cmd_q   <= s1_cmd_q;
      // timestamps only matter for latency requests
      s2_drop_q  <= drop_c && (s1_cmd_q == p2lh_pkg::CMD_LATENCY);
      s2_dsec_q  <= s1_dsec_q[45:0];
      s2_mag_q   <= mag_c;
      s2_neg_q   <= s1_dns_q[30];
      s2_plain_q <= s1_plain_q;
      s2_ridx_q  <= s1_ridx_q;

      s3_cmd_q   <= s2_cmd_q;
      s3_drop_q  <= s2_drop_q;
      s3_base_q  <= base_full_c[63:0];
      s3_prod_q  <= 63'(s2_mag_q) * 63'(p2lh_pkg::DIV_RECIP);
      s3_neg_q   <= s2_neg_q;
      s3_plain_q <= s2_plain_q;
      s3_ridx_q  <= s2_ridx_q;

      s4_item_q  <= s4_item_d;
    end
  end

  assign vld_o  = s4_vld_q;
  assign item_o = s4_item_q;

endmodule

>>> sv/p2lh_log2.sv
// Bin-index pipeline: ceiling log2 of the microsecond count in three stages.
module p2lh_log2 (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                en_i,
  input  logic                vld_i,
  input  p2lh_pkg::us_item_t  item_i,
  output logic                vld_o,
  output p2lh_pkg::bin_item_t item_o
);

  localparam int unsigned NCHUNK = 8;
  localparam int unsigned CHUNKW = 8;

  // stage 1: value minus one
  logic           l1_vld_q;
  p2lh_pkg::cmd_e l1_cmd_q;
  logic           l1_drop_q;
  logic [63:0]    l1_r_q;
  logic           l1_zero_q;
  logic [4:0]     l1_ridx_q;

  // stage 2: per-byte leading-one detect
  logic           l2_vld_q;
  p2lh_pkg::cmd_e l2_cmd_q;
  logic           l2_drop_q;
  logic [NCHUNK-1:0] l2_nz_q, nz_c;
  logic [2:0]     l2_hi_q [NCHUNK], hi_c [NCHUNK];
  logic [4:0]     l2_ridx_q;

  // stage 3: bin index
  logic                l3_vld_q;
  p2lh_pkg::bin_item_t l3_item_q, l3_item_d;

  always_comb begin
    for (int c = 0; c < NCHUNK; c++) begin
      nz_c[c] = |l1_r_q[c*CHUNKW +: CHUNKW];
      hi_c[c] = 3'd0;
      for (int j = 0; j < CHUNKW; j++) begin
        if (l1_r_q[c*CHUNKW + j]) begin
          hi_c[c] = 3'(j);
        end
      end
    end
  end

  always_comb begin
    l3_item_d.cmd        = l2_cmd_q;
    l3_item_d.drop       = l2_drop_q;
    l3_item_d.read_index = l2_ridx_q;
    l3_item_d.k          = 7'd0;
    for (int c = 0; c < NCHUNK; c++) begin
      if (l2_nz_q[c]) begin
        l3_item_d.k = 7'(c * CHUNKW) + 7'(l2_hi_q[c]) + 7'd1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      l1_vld_q <= 1'b0;
      l2_vld_q <= 1'b0;
      l3_vld_q <= 1'b0;
    end else if (en_i) begin
      l1_vld_q <= vld_i;
      l2_vld_q <= l1_vld_q;
      l3_vld_q <= l2_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      l1_cmd_q  <= item_i.cmd;
      l1_drop_q <= item_i.drop;
      l1_r_q    <= item_i.us - 64'd1;
      l1_zero_q <= (item_i.us == 64'd0);
      l1_ridx_q <= item_i.read_index;

      l2_cmd_q  <= l1_cmd_q;
      l2_drop_q <= l1_drop_q;
      // zero microseconds goes to bin 0 like one
      l2_nz_q   <= l1_zero_q ? '0 : nz_c;
      l2_hi_q   <= hi_c;
      l2_ridx_q <= l1_ridx_q;

      l3_item_q <= l3_item_d;
    end
  end

  assign vld_o  = l3_vld_q;
  assign item_o = l3_item_q;

endmodule

>>> sv/p2lh_bank.sv
// Counter bank: synchronous counter memory with read-modify-write and output register.
module p2lh_bank #(
  parameter int unsigned BIN_COUNT = p2lh_pkg::BIN_COUNT_DEF
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                en_i,
  input  logic                vld_i,
  input  p2lh_pkg::bin_item_t item_i,
  output logic                out_vld_o,
  output logic [4:0]          bin_index_o,
  output logic [63:0]         bin_count_o,
  output p2lh_pkg::status_e   status_o
);

  localparam int unsigned AW = (BIN_COUNT > 1) ? $clog2(BIN_COUNT) : 1;

  typedef enum logic [1:0] {
    OP_REC  = 2'd0,
    OP_READ = 2'd1,
    OP_DROP = 2'd2
  } op_e;

  logic [63:0]          mem [BIN_COUNT];
  logic [BIN_COUNT-1:0] vld_q;

  op_e         op_c;
  logic [6:0]  idx_c;
  logic [AW-1:0] addr_c;

  // read stage
  logic          q_vld_q;
  op_e           q_op_q;
  logic [6:0]    q_idx_q;
  logic [AW-1:0] q_addr_q;
  logic [63:0]   rd_data_q;
  logic          rd_hit_q;

  // last write, forwarded to the request right behind it
  logic          lw_vld_q;
  logic [AW-1:0] lw_addr_q;
  logic [63:0]   lw_data_q;

  logic [63:0]   cur_c, inc_c;

  // output register
  logic              out_vld_q;
  logic [4:0]        out_idx_q;
  logic [63:0]       out_cnt_q;
  p2lh_pkg::status_e out_st_q;

  always_comb begin
    op_c  = OP_DROP;
    idx_c = 7'd0;
    case (item_i.cmd)
      p2lh_pkg::CMD_LATENCY, p2lh_pkg::CMD_VALUE: begin
        if (!item_i.drop && item_i.k < 7'(BIN_COUNT)) begin
          op_c  = OP_REC;
          idx_c = item_i.k;
        end
      end
      p2lh_pkg::CMD_READ: begin
        if (7'(item_i.read_index) < 7'(BIN_COUNT)) begin
          op_c  = OP_READ;
          idx_c = 7'(item_i.read_index);
        end
      end
      default: begin
        op_c = OP_DROP;
      end
    endcase
    addr_c = idx_c[AW-1:0];
  end

  always_comb begin
    if (lw_vld_q && lw_addr_q == q_addr_q) begin
      cur_c = lw_data_q;
    end else if (rd_hit_q) begin
      cur_c = rd_data_q;
    end else begin
      cur_c = 64'd0;
    end
    inc_c = cur_c + 64'd1;
  end

  // memory array: one read, one write per enabled cycle, registered read
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      rd_data_q <= mem[addr_c];
      if (q_vld_q && q_op_q == OP_REC) begin
        mem[q_addr_q] <= inc_c;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q     <= '0;
      q_vld_q   <= 1'b0;
      lw_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
    end else if (en_i) begin
      q_vld_q   <= vld_i;
      out_vld_q <= q_vld_q;
      if (q_vld_q && q_op_q == OP_REC) begin
        vld_q[q_addr_q] <= 1'b1;
        lw_vld_q        <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      q_op_q   <= op_c;
      q_idx_q  <= idx_c;
      q_addr_q <= addr_c;
      rd_hit_q <= vld_q[addr_c];
      if (q_vld_q && q_op_q == OP_REC) begin
        lw_addr_q <= q_addr_q;
        lw_data_q <= inc_c;
      end
      case (q_op_q)
        OP_REC: begin
          out_idx_q <= q_idx_q[4:0];
          out_cnt_q <= inc_c;
          out_st_q  <= p2lh_pkg::ST_RECORDED;
        end
        OP_READ: begin
          out_idx_q <= q_idx_q[4:0];
          out_cnt_q <= cur_c;
          out_st_q  <= p2lh_pkg::ST_READ;
        end
        default: begin
          out_idx_q <= 5'd0;
          out_cnt_q <= 64'd0;
          out_st_q  <= p2lh_pkg::ST_DROPPED;
        end
      endcase
    end
  end

  assign out_vld_o   = out_vld_q;
  assign bin_index_o = out_idx_q;
  assign bin_count_o = out_cnt_q;
  assign status_o    = out_st_q;

endmodule

>>> sv/pow2_latency_histogram_top.sv
// Top level of the power-of-two latency histogram.
//
//  channel  dir  side-band            contents
//  s_axis   in   tuser = cmd          timestamps, plain value, read index
//  m_axis   out  tuser = status       bin index, bin count
//
// One request per cycle while m_axis is not stalled.
// The pipeline is 4 duration stages, 3 log2 stages, the counter memory
// read stage and the output register; the counter update is one read and
// one write per cycle with the previous write forwarded.
// Reset clears all counters at once through per-bin valid flags.
// A stall on m_axis freezes the whole pipeline; s_axis_tready drops with it.
module pow2_latency_histogram_top #(
  parameter int unsigned BIN_COUNT = p2lh_pkg::BIN_COUNT_DEF
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  // [62:0] start_sec, [92:63] start_nsec, [155:93] end_sec,
  // [185:156] end_nsec, [216:186] plain_value, [221:217] read_index, [223:222] zero
  input  logic [223:0] s_axis_tdata,
  // [1:0] cmd
  input  logic [1:0]   s_axis_tuser,
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // [4:0] bin_index, [68:5] bin_count, [71:69] zero
  output logic [71:0]  m_axis_tdata,
  // [1:0] status
  output logic [1:0]   m_axis_tuser
);

  logic                en;
  logic                dur_vld, lg_vld;
  p2lh_pkg::us_item_t  dur_item;
  p2lh_pkg::bin_item_t lg_item;
  logic [4:0]          bin_index;
  logic [63:0]         bin_count;
  p2lh_pkg::status_e   status;

  assign en            = !m_axis_tvalid || m_axis_tready;
  assign s_axis_tready = en;

  p2lh_dur u_dur (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .en_i          (en),
    .vld_i         (s_axis_tvalid),
    .cmd_i         (p2lh_pkg::cmd_e'(s_axis_tuser)),
    .start_sec_i   (s_axis_tdata[62:0]),
    .start_nsec_i  (s_axis_tdata[92:63]),
    .end_sec_i     (s_axis_tdata[155:93]),
    .end_nsec_i    (s_axis_tdata[185:156]),
    .plain_value_i (s_axis_tdata[216:186]),
    .read_index_i  (s_axis_tdata[221:217]),
    .vld_o         (dur_vld),
    .item_o        (dur_item)
  );

  p2lh_log2 u_log2 (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (en),
    .vld_i  (dur_vld),
    .item_i (dur_item),
    .vld_o  (lg_vld),
    .item_o (lg_item)
  );

  p2lh_bank #(
    .BIN_COUNT (BIN_COUNT)
  ) u_bank (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .en_i        (en),
    .vld_i       (lg_vld),
    .item_i      (lg_item),
    .out_vld_o   (m_axis_tvalid),
    .bin_index_o (bin_index),
    .bin_count_o (bin_count),
    .status_o    (status)
  );

  assign m_axis_tdata = {3'b000, bin_count, bin_index};
  assign m_axis_tuser = status;

endmodule

>>> dv/tb_pow2_latency_histogram_top.sv
// Self-checking testbench for pow2_latency_histogram_top: directed table, then random requests.
module tb_pow2_latency_histogram_top;

  localparam int          NBINS       = p2lh_pkg::BIN_COUNT_DEF;
  localparam int          CYCLE_LIMIT = 200000;
  localparam int          N_RANDOM    = 1700;
  localparam int          DRAIN       = 30;
  localparam logic [1:0]  CMD_UNUSED  = 2'd3;
  localparam logic [62:0] SEC_MAX     = '1;
  localparam logic [29:0] NSEC_ALL    = '1;
  localparam logic [29:0] NSEC_MAX    = 30'd999999999;
  localparam logic [30:0] VALUE_MAX   = '1;

  typedef struct {
    logic [1:0]  cmd;
    logic [62:0] start_sec;
    logic [29:0] start_nsec;
    logic [62:0] end_sec;
    logic [29:0] end_nsec;
    logic [30:0] plain_value;
    logic [4:0]  read_index;
  } hist_req_t;

  typedef struct {
    logic [4:0]        bin_index;
    logic [63:0]       bin_count;
    p2lh_pkg::status_e status;
  } hist_result_t;

  typedef struct {
    hist_req_t    req;
    bit           fixed;
    hist_result_t res;
  } table_row_t;

  logic         clk_i;
  logic         rst_ni;
  logic         s_axis_tvalid;
  logic         s_axis_tready;
  logic [223:0] s_axis_tdata;
  logic [1:0]   s_axis_tuser;
  logic         m_axis_tvalid;
  logic         m_axis_tready;
  logic [71:0]  m_axis_tdata;
  logic [1:0]   m_axis_tuser;

  logic [63:0]  shadow_bins [NBINS];
  hist_result_t expected_results [$];
  table_row_t   directed_rows [$];
  bit           quiet;
  int           errors;
  int           cycles;
  int           req_per_cmd [4];
  int           dropped_seen;
  logic [31:0]  bins_hit;

  pow2_latency_histogram_top DUT (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tuser (m_axis_tuser)
  );

  initial begin
    clk_i         = 1'b0;
    rst_ni        = 1'b0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    s_axis_tuser  = '0;
    m_axis_tready = 1'b0;
  end

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("%0t: timeout, %0d results still outstanding", $time, expected_results.size());
      $display("** pow2_latency_histogram_top: FAILED **");
      $finish;
    end
  end

  always @(negedge clk_i) begin
    m_axis_tready <= quiet || ($urandom_range(0, 99) >= 9);
  end

  // Applies one request to the shadow counters and returns the result it should produce.
  function automatic hist_result_t histogram_apply(input hist_req_t r);
    hist_result_t     res;
    logic signed [127:0] ss, sn, es, en, ns;
    logic [127:0]     us, rem;
    bit               binnable;
    int               k;
    res.bin_index = '0;
    res.bin_count = '0;
    res.status    = p2lh_pkg::ST_DROPPED;
    binnable      = 1'b0;
    us            = '0;
    k             = 0;
    case (r.cmd)
      p2lh_pkg::CMD_LATENCY: begin
        ss = 128'(r.start_sec);
        sn = 128'(r.start_nsec);
        es = 128'(r.end_sec);
        en = 128'(r.end_nsec);
        ns = (es - ss) * 128'sd1000000000 + en - sn;
        if (ns >= 0) begin
          us = (ns + 999) / 1000;
          binnable = 1'b1;
        end
      end
      p2lh_pkg::CMD_VALUE: begin
        us = 128'(r.plain_value);
        binnable = 1'b1;
      end
      p2lh_pkg::CMD_READ: begin
        if (r.read_index < NBINS) begin
          res.bin_index = r.read_index;
          res.bin_count = shadow_bins[r.read_index];
          res.status    = p2lh_pkg::ST_READ;
        end
      end
      default: ;
    endcase
    if (binnable) begin
      // ceil(log2(us)): bit length of us-1
      if (us > 1) begin
        rem = us - 1;
        while (rem != 0) begin
          rem = rem >> 1;
          k++;
        end
      end
      if (k < NBINS) begin
        shadow_bins[k] = shadow_bins[k] + 64'd1;
        res.bin_index  = k[4:0];
        res.bin_count  = shadow_bins[k];
        res.status     = p2lh_pkg::ST_RECORDED;
      end
    end
    return res;
  endfunction

  function automatic logic [62:0] rnd63();
    logic [63:0] v;
    v = {$urandom(), $urandom()};
    return v[62:0];
  endfunction

  function automatic hist_req_t random_request();
    hist_req_t r;
    int        pick;
    logic [62:0] delta;
    logic [29:0] tmp;
    // unused fields carry noise
    r.start_sec   = rnd63();
    r.start_nsec  = 30'($urandom_range(0, 30'h3fffffff));
    r.end_sec     = rnd63();
    r.end_nsec    = 30'($urandom_range(0, 30'h3fffffff));
    r.plain_value = 31'($urandom_range(0, 32'h7fffffff));
    r.read_index  = 5'($urandom_range(0, 31));
    pick = $urandom_range(0, 99);
    if (pick < 50)      r.cmd = p2lh_pkg::CMD_LATENCY;
    else if (pick < 75) r.cmd = p2lh_pkg::CMD_VALUE;
    else if (pick < 95) r.cmd = p2lh_pkg::CMD_READ;
    else                r.cmd = CMD_UNUSED;
    if (r.cmd == p2lh_pkg::CMD_LATENCY) begin
      r.start_sec = rnd63() >> $urandom_range(0, 62);
      pick = $urandom_range(0, 99);
      if (pick < 40) begin
        // same second, short interval
        r.start_nsec = 30'($urandom_range(0, NSEC_MAX));
        r.end_sec    = r.start_sec;
        r.end_nsec   = r.start_nsec + (NSEC_ALL >> $urandom_range(0, 30)
                       & 30'($urandom_range(0, 30'h3fffffff)));
      end else if (pick < 70) begin
        r.start_nsec = 30'($urandom_range(0, NSEC_MAX));
        r.end_nsec   = 30'($urandom_range(0, NSEC_MAX));
        r.end_sec    = r.start_sec + 63'($urandom_range(1, 2200));
      end else if (pick < 80) begin
        r.end_sec    = r.start_sec + 63'($urandom_range(0, 3));
      end else if (pick < 90) begin
        // end second at or before start second, nanosecond fields swapped
        delta        = 63'($urandom_range(0, 2)) << ($urandom_range(0, 1) * $urandom_range(0, 60));
        r.end_sec    = r.start_sec;
        r.start_sec  = r.start_sec + delta;
        tmp          = r.start_nsec;
        r.start_nsec = r.end_nsec;
        r.end_nsec   = tmp;
      end
    end else if (r.cmd == p2lh_pkg::CMD_VALUE) begin
      r.plain_value = r.plain_value >> $urandom_range(0, 31);
    end
    return r;
  endfunction

  task automatic send_request(input hist_req_t r, input bit fixed, input hist_result_t fixed_res);
    hist_result_t predicted;
    while (!quiet && $urandom_range(0, 99) < 9) begin
      @(negedge clk_i);
      s_axis_tvalid <= 1'b0;
    end
    @(negedge clk_i);
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {2'b00, r.read_index, r.plain_value, r.end_nsec, r.end_sec,
                      r.start_nsec, r.start_sec};
    s_axis_tuser  <= r.cmd;
    do @(posedge clk_i); while (!s_axis_tready);
    predicted = histogram_apply(r);
    expected_results.push_back(fixed ? fixed_res : predicted);
    req_per_cmd[r.cmd]++;
  endtask

  task automatic drain_pause();
    @(negedge clk_i);
    s_axis_tvalid <= 1'b0;
    wait (expected_results.size() == 0);
  endtask

  task automatic add_row(input logic [1:0] cmd, input logic [62:0] ss, input logic [29:0] sn,
                         input logic [62:0] es, input logic [29:0] en, input logic [30:0] pv,
                         input logic [4:0] ri, input bit fixed, input logic [4:0] idx,
                         input logic [63:0] cnt, input p2lh_pkg::status_e st);
    table_row_t row;
    row.req.cmd         = cmd;
    row.req.start_sec   = ss;
    row.req.start_nsec  = sn;
    row.req.end_sec     = es;
    row.req.end_nsec    = en;
    row.req.plain_value = pv;
    row.req.read_index  = ri;
    row.fixed           = fixed;
    row.res.bin_index   = idx;
    row.res.bin_count   = cnt;
    row.res.status      = st;
    directed_rows.push_back(row);
  endtask

  always @(posedge clk_i) begin : result_check
    hist_result_t want;
    logic [4:0]   got_idx;
    logic [63:0]  got_cnt;
    got_idx = m_axis_tdata[4:0];
    got_cnt = m_axis_tdata[68:5];
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (expected_results.size() == 0) begin
        errors++;
        $display("%0t: unexpected result idx %0d count %0d status %0d",
                 $time, got_idx, got_cnt, m_axis_tuser);
      end else begin
        want = expected_results.pop_front();
        if (got_idx !== want.bin_index || got_cnt !== want.bin_count ||
            m_axis_tuser !== want.status) begin
          errors++;
          $display("%0t: mismatch: expected idx %0d count %0d status %0d,",
                   $time, want.bin_index, want.bin_count, want.status);
          $display("%0t:           got idx %0d count %0d status %0d",
                   $time, got_idx, got_cnt, m_axis_tuser);
        end
        if (m_axis_tuser == p2lh_pkg::ST_DROPPED) dropped_seen++;
        if (m_axis_tuser == p2lh_pkg::ST_RECORDED) bins_hit[got_idx] = 1'b1;
      end
    end
  end

  initial begin : stimulus
    hist_result_t none;
    none.bin_index = '0;
    none.bin_count = '0;
    none.status    = p2lh_pkg::ST_DROPPED;
    quiet    = 1'b0;
    errors   = 0;
    cycles   = 0;
    bins_hit = '0;
    dropped_seen = 0;
    foreach (req_per_cmd[i]) req_per_cmd[i] = 0;
    foreach (shadow_bins[i]) shadow_bins[i] = '0;

    //      cmd                    ss       sn        es       en        value   rd fix idx cnt st
    add_row(p2lh_pkg::CMD_READ,    0,       0,        0,       0,        0,      0,  1, 0,  0,
            p2lh_pkg::ST_READ);
    add_row(p2lh_pkg::CMD_READ,    0,       0,        0,       0,        0,      31, 1, 31, 0,
            p2lh_pkg::ST_READ);
    add_row(p2lh_pkg::CMD_LATENCY, 0,       0,        0,       0,        0,      0,  1, 0,  1,
            p2lh_pkg::ST_RECORDED);
    add_row(p2lh_pkg::CMD_VALUE,   0,       0,        0,       0,        0,      0,  1, 0,  2,
            p2lh_pkg::ST_RECORDED);
    add_row(p2lh_pkg::CMD_VALUE,   0,       0,        0,       0,        1,      0,  1, 0,  3,
            p2lh_pkg::ST_RECORDED);
    add_row(p2lh_pkg::CMD_VALUE,   0,       0,        0,       0,        2,      0,  1, 1,  1,
            p2lh_pkg::ST_RECORDED);
    add_row(p2lh_pkg::CMD_VALUE,   0,       0,        0,       0,        VALUE_MAX, 0, 1, 31, 1,
            p2lh_pkg::ST_RECORDED);
    add_row(p2lh_pkg::CMD_VALUE,   0,       0,        0,       0,        31'h40000001, 0, 1, 31, 2,
            p2lh_pkg::ST_RECORDED);
    // negative and short durations
    add_row(p2lh_pkg::CMD_LATENCY, 5,       0,        0,       0,        0,      0,  1, 0,  0,
            p2lh_pkg::ST_DROPPED);
    add_row(p2lh_pkg::CMD_LATENCY, 7,       500,      7,       499,      0,      0,  1, 0,  0,
            p2lh_pkg::ST_DROPPED);
    add_row(p2lh_pkg::CMD_LATENCY, 7,       500,      7,       501,      0,      0,  1, 0,  4,
            p2lh_pkg::ST_RECORDED);
    add_row(p2lh_pkg::CMD_LATENCY, 9,       0,        9,       1000,     0,      0,  0, 0,  0,
            p2lh_pkg::ST_RECORDED);
    add_row(p2lh_pkg::CMD_LATENCY, 9,       0,        9,       1001,     0,      0,  0, 0,  0,
            p2lh_pkg::ST_RECORDED);
    // end second one below start, nanoseconds past a second, then whole-second spans
    add_row(p2lh_pkg::CMD_LATENCY, 1,       0,        0,       NSEC_ALL, 0,      0,  0, 0,  0,
            p2lh_pkg::ST_RECORDED);
    add_row(p2lh_pkg::CMD_LATENCY, 1,       NSEC_MAX, 0,       NSEC_ALL, 0,      0,  1, 0,  0,
            p2lh_pkg::ST_DROPPED);
    add_row(p2lh_pkg::CMD_LATENCY, 0,       0,        2,       0,        0,      0,  0, 0,  0,
            p2lh_pkg::ST_RECORDED);
    add_row(p2lh_pkg::CMD_LATENCY, 0,       NSEC_MAX, 3,       0,        0,      0,  0, 0,  0,
            p2lh_pkg::ST_RECORDED);
    // last bin edge, then extreme timestamps, an unused command and reads
    add_row(p2lh_pkg::CMD_LATENCY, 100,     0,        2247,    0,        0,      0,  0, 0,  0,
            p2lh_pkg::ST_RECORDED);
    add_row(p2lh_pkg::CMD_LATENCY, 100,     0,        2248,    0,        0,      0,  1, 0,  0,
            p2lh_pkg::ST_DROPPED);
    add_row(p2lh_pkg::CMD_LATENCY, 0,       0,        SEC_MAX, 0,        0,      0,  1, 0,  0,
            p2lh_pkg::ST_DROPPED);
    add_row(p2lh_pkg::CMD_LATENCY, SEC_MAX, NSEC_ALL, SEC_MAX, NSEC_ALL, 0,      0,  0, 0,  0,
            p2lh_pkg::ST_RECORDED);
    add_row(p2lh_pkg::CMD_LATENCY, SEC_MAX, 0,        0,       0,        0,      0,  1, 0,  0,
            p2lh_pkg::ST_DROPPED);
    add_row(CMD_UNUSED,            SEC_MAX, NSEC_ALL, SEC_MAX, NSEC_ALL, VALUE_MAX, 31, 1, 0, 0,
            p2lh_pkg::ST_DROPPED);
    add_row(p2lh_pkg::CMD_READ,    0,       0,        0,       0,        0,      31, 0, 0,  0,
            p2lh_pkg::ST_READ);
    add_row(p2lh_pkg::CMD_READ,    0,       0,        0,       0,        0,      0,  0, 0,  0,
            p2lh_pkg::ST_READ);

    repeat (3) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    foreach (directed_rows[i])
      send_request(directed_rows[i].req, directed_rows[i].fixed, directed_rows[i].res);
    drain_pause();

    for (int n = 0; n < N_RANDOM; n++) begin
      quiet = (n >= 500 && n < 900);
      if (n == 1200) drain_pause();
      send_request(random_request(), 1'b0, none);
    end
    quiet = 1'b0;
    @(negedge clk_i);
    s_axis_tvalid <= 1'b0;
    wait (expected_results.size() == 0);
    repeat (DRAIN) @(posedge clk_i);

    $display("Requests: %0d latency, %0d value, %0d read, %0d unused; %0d dropped results",
             req_per_cmd[0], req_per_cmd[1], req_per_cmd[2], req_per_cmd[3], dropped_seen);
    $display("Bins recorded into: %0d of %0d", $countones(bins_hit), NBINS);
    if (errors == 0) begin
      $display("** pow2_latency_histogram_top: PASSED **");
    end else begin
      $display("** pow2_latency_histogram_top: FAILED **");
    end
    $finish;
  end

endmodule

>>> pow2_latency_histogram_top.f
sv/p2lh_pkg.sv
sv/p2lh_dur.sv
sv/p2lh_log2.sv
sv/p2lh_bank.sv
sv/pow2_latency_histogram_top.sv
dv/tb_pow2_latency_histogram_top.sv
